// ----- sv/cpc_pkg.sv -----
// Shared types, constants and elaboration-time table functions for the converter.
package cpc_pkg;

   localparam int GUARD_BITS  = 24;
   localparam int COORD_W     = 60;
   localparam int MAG_W       = 59;
   localparam int TABLE_MAX   = 48;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic [1:0] FORM_CART    = 2'd0;
   localparam logic [1:0] FORM_POLAR   = 2'd1;
   localparam logic [1:0] FORM_INVALID = 2'd2;
   localparam logic [1:0] FORM_UNUSED  = 2'd3;

   localparam logic [63:0] TWO_OVER_PI_Q64 = 64'hA2F9_836E_4E44_1529;
   localparam logic [63:0] KINV_SEED_Q62   = 64'h9B74_EDA8 << 30;
   localparam logic [63:0] THREE_Q62       = 64'hC000_0000_0000_0000;

   typedef struct packed {
      logic polar;
      logic bad;
      logic zero;
   } cpc_ctrl_type;

   // Restoring division, used only while building constants.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[125:62];
   endfunction

   // Arctangent of 2^-idx with pi at 2^64, from the truncated Taylor series.
   function automatic logic [63:0] atan_full(input int idx);
      logic [63:0]  sum;
      logic [63:0]  term;
      logic [127:0] prod;
      int           sh;
      sum = '0;
      if (idx == 0) begin
         return 64'd1 << 62;
      end
      for (int n = 0; n < 32; n++) begin
         sh = idx * (2 * n + 1);
         if (sh < 64) begin
            term = 64'h8000_0000_0000_0000 >> sh;
            term = udiv64(term, 64'(2 * n + 1));
            if (n % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
      end
      prod = {64'd0, sum} * {64'd0, TWO_OVER_PI_Q64};
      return prod[127:64];
   endfunction

   function automatic logic [63:0] atan_entry(input int idx, input int dw);
      logic [64:0] t;
      t = {1'b0, atan_full(idx)} + (65'd1 << (64 - dw));
      return 64'(t >> (65 - dw));
   endfunction

   // Inverse CORDIC gain in Q62 for a given number of micro-rotations.
   function automatic logic [63:0] kinv_q62(input int stages);
      logic [63:0] k2;
      logic [63:0] r;
      logic [63:0] t;
      k2 = 64'd1 << 63;
      for (int i = 1; i < TABLE_MAX; i++) begin
         if (i < stages && 2 * i < 63) begin
            k2 = k2 + (k2 >> (2 * i));
         end
      end
      r = KINV_SEED_Q62;
      for (int it = 0; it < 3; it++) begin
         t = mul_q62(k2, mul_q62(r, r));
         r = mul_q62(r, THREE_Q62 - t) >> 1;
      end
      return r;
   endfunction

endpackage

// ----- sv/cartesian_polar_converter.sv -----
// Cartesian/polar converter: one result per request, CORDIC pipeline of CORDIC_STAGES steps.
// A request passes through the queue, the micro-rotation stage registers and the magnitude,
// partial-product, sum and result registers before its result is presented on rsp.
// Throughput: one request per cycle; the unrolled CORDIC pipeline advances as a unit.
// Backpressure on rsp stalls the pipeline; a four-entry queue keeps taking requests until full.
// Reset is synchronous and active high; it clears the queue and all valid bits.
module cartesian_polar_converter #(
   parameter int CORDIC_STAGES = 32,
   parameter int DATA_WIDTH    = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // first_value[31:0], second_value[63:32]
   input  logic [1:0]   req_tuser,   // form[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // x_coord, y_coord, magnitude(33), angle, zero fill
   output logic [1:0]   rsp_tuser    // polar_mode, bad_form
);

   localparam int CW = cpc_pkg::COORD_W;
   localparam int QW = $bits(cpc_pkg::cpc_ctrl_type) + 2 * CW + DATA_WIDTH + 64;

   cpc_pkg::cpc_ctrl_type  f_ctrl, q_ctrl;
   logic signed [CW-1:0]   f_x, f_y, q_x, q_y;
   logic [DATA_WIDTH-1:0]  f_z, q_z;
   logic signed [31:0]     q_a, q_b;
   logic [QW-1:0]          push_data, pop_data;
   logic                   q_full, q_empty, q_push, q_pop;
   logic signed [31:0]     x_coord, y_coord, angle;
   logic signed [32:0]     magnitude;
   logic                   polar_mode, bad_form;

   cpc_front #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_front (
      .form        (req_tuser),
      .first_value ($signed(req_tdata[31:0])),
      .second_value($signed(req_tdata[63:32])),
      .ctrl        (f_ctrl),
      .x_start     (f_x),
      .y_start     (f_y),
      .z_start     (f_z)
   );

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;
   assign push_data  = {f_ctrl, f_x, f_y, f_z, req_tdata[31:0], req_tdata[63:32]};

   cpc_queue #(
      .WIDTH(QW)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(push_data),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (pop_data),
      .empty    (q_empty)
   );

   assign {q_ctrl, q_x, q_y, q_z, q_a, q_b} = pop_data;

   cpc_back #(
      .CORDIC_STAGES(CORDIC_STAGES),
      .DATA_WIDTH   (DATA_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .item_avail(!q_empty),
      .item_pop  (q_pop),
      .ctrl      (q_ctrl),
      .x_start   (q_x),
      .y_start   (q_y),
      .z_start   (q_z),
      .a_echo    (q_a),
      .b_echo    (q_b),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .x_coord   (x_coord),
      .y_coord   (y_coord),
      .magnitude (magnitude),
      .angle     (angle),
      .polar_mode(polar_mode),
      .bad_form  (bad_form)
   );

   assign rsp_tdata = {7'd0, angle, magnitude, y_coord, x_coord};
   assign rsp_tuser = {bad_form, polar_mode};

endmodule

// ----- sv/cpc_front.sv -----
// Front end: decodes the form code and prepares the starting vector and angle.
module cpc_front #(
   parameter int DATA_WIDTH = 32
) (
   input  logic [1:0]                         form,
   input  logic signed [31:0]                 first_value,
   input  logic signed [31:0]                 second_value,
   output cpc_pkg::cpc_ctrl_type              ctrl,
   output logic signed [cpc_pkg::COORD_W-1:0] x_start,
   output logic signed [cpc_pkg::COORD_W-1:0] y_start,
   output logic [DATA_WIDTH-1:0]              z_start
);

   localparam logic [DATA_WIDTH-1:0] HALF = DATA_WIDTH'(1) << (DATA_WIDTH - 1);

   logic signed [32:0]    a_ext;
   logic signed [32:0]    b_ext;
   logic signed [32:0]    x_sel;
   logic signed [32:0]    y_sel;
   logic [DATA_WIDTH-1:0] ang_in;
   logic [DATA_WIDTH-1:0] z_sel;
   logic [1:0]            quad;
   logic                  flip;

   generate
      if (DATA_WIDTH >= 32) begin : g_ang_wide
         assign ang_in = DATA_WIDTH'($unsigned(second_value)) << (DATA_WIDTH - 32);
      end else begin : g_ang_narrow
         logic [32:0] rnd;
         assign rnd    = {1'b0, $unsigned(second_value)} + (33'd1 << (31 - DATA_WIDTH));
         assign ang_in = DATA_WIDTH'(rnd >> (32 - DATA_WIDTH));
      end
   endgenerate

   assign a_ext = 33'(first_value);
   assign b_ext = 33'(second_value);
   assign quad  = ang_in[DATA_WIDTH-1 -: 2];
   assign flip  = (quad == 2'b01) || (quad == 2'b10);

   always_comb begin
      ctrl  = '0;
      x_sel = '0;
      y_sel = '0;
      z_sel = '0;
      unique case (form)
         cpc_pkg::FORM_CART: begin
            ctrl.zero = (first_value == 32'sd0) && (second_value == 32'sd0);
            // Left half-plane vectors are turned by pi so the iterations converge.
            if (first_value < 0) begin
               x_sel = -a_ext;
               y_sel = -b_ext;
               z_sel = HALF;
            end else begin
               x_sel = a_ext;
               y_sel = b_ext;
            end
         end
         cpc_pkg::FORM_POLAR: begin
            ctrl.polar = 1'b1;
            if (flip) begin
               x_sel = -a_ext;
               z_sel = ang_in + HALF;
            end else begin
               x_sel = a_ext;
               z_sel = ang_in;
            end
         end
         default: begin
            ctrl.bad = 1'b1;
         end
      endcase
   end

   assign x_start = cpc_pkg::COORD_W'(x_sel) <<< cpc_pkg::GUARD_BITS;
   assign y_start = cpc_pkg::COORD_W'(y_sel) <<< cpc_pkg::GUARD_BITS;
   assign z_start = z_sel;

endmodule

// ----- sv/cpc_queue.sv -----
// Short request queue between the front end and the CORDIC back end.
module cpc_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0]          mem_ff [cpc_pkg::QUEUE_DEPTH];
   logic [cpc_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cpc_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cpc_pkg::QPTR_W:0]   count_ff, count_in;

   assign full     = (count_ff == (cpc_pkg::QPTR_W + 1)'(cpc_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (cpc_pkg::QPTR_W + 1)'(push) - (cpc_pkg::QPTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("queue popped while empty");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff == $past(count_in))
      else $error("queue count lost track");
`endif

endmodule

// ----- sv/cpc_back.sv -----
// Back end: unrolled CORDIC pipeline, gain correction, rounding and result register.
module cpc_back #(
   parameter int CORDIC_STAGES = 32,
   parameter int DATA_WIDTH    = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               item_avail,
   output logic                               item_pop,
   input  cpc_pkg::cpc_ctrl_type              ctrl,
   input  logic signed [cpc_pkg::COORD_W-1:0] x_start,
   input  logic signed [cpc_pkg::COORD_W-1:0] y_start,
   input  logic [DATA_WIDTH-1:0]              z_start,
   input  logic signed [31:0]                 a_echo,
   input  logic signed [31:0]                 b_echo,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [31:0]                 x_coord,
   output logic signed [31:0]                 y_coord,
   output logic signed [32:0]                 magnitude,
   output logic signed [31:0]                 angle,
   output logic                               polar_mode,
   output logic                               bad_form
);

   localparam int CW = cpc_pkg::COORD_W;
   localparam int MW = cpc_pkg::MAG_W;
   localparam int N  = CORDIC_STAGES;
   localparam logic [63:0] KINV    = cpc_pkg::kinv_q62(CORDIC_STAGES);
   localparam logic [30:0] KINV_LO = KINV[30:0];
   localparam logic [30:0] KINV_HI = KINV[61:31];

   logic adv;

   // CORDIC stage registers; entry k holds the vector after k micro-rotations.
   logic                      v_ff [0:N];
   cpc_pkg::cpc_ctrl_type     c_ff [0:N];
   logic signed [CW-1:0]      x_ff [0:N];
   logic signed [CW-1:0]      y_ff [0:N];
   logic [DATA_WIDTH-1:0]     z_ff [0:N];
   logic signed [31:0]        a_ff [0:N];
   logic signed [31:0]        b_ff [0:N];
   logic signed [CW-1:0]      x_in [0:N-1];
   logic signed [CW-1:0]      y_in [0:N-1];
   logic [DATA_WIDTH-1:0]     z_in [0:N-1];

   generate
      for (genvar k = 0; k < N; k++) begin : g_stage
         localparam logic [63:0] AT = cpc_pkg::atan_entry(k, DATA_WIDTH);
         logic signed [CW-1:0] dx;
         logic signed [CW-1:0] dy;
         logic                 turn_neg;
         assign dx = y_ff[k] >>> k;
         assign dy = x_ff[k] >>> k;
         // Vectoring drives y toward zero; rotation drives the residual angle to zero.
         assign turn_neg = c_ff[k].polar ? z_ff[k][DATA_WIDTH-1] : !y_ff[k][CW-1];
         always_comb begin
            if (turn_neg) begin
               x_in[k] = x_ff[k] + dx;
               y_in[k] = y_ff[k] - dy;
               z_in[k] = z_ff[k] + AT[DATA_WIDTH-1:0];
            end else begin
               x_in[k] = x_ff[k] - dx;
               y_in[k] = y_ff[k] + dy;
               z_in[k] = z_ff[k] - AT[DATA_WIDTH-1:0];
            end
         end
      end
   endgenerate

   // Tail stages: absolute value, partial products, product sum, result.
   logic                  av_ff, mv_ff, sv_ff, out_v_ff;
   cpc_pkg::cpc_ctrl_type ac_ff, mc_ff, sc_ff, out_c_ff;
   logic [DATA_WIDTH-1:0] az_ff, mz_ff, sz_ff;
   logic signed [31:0]    aa_ff, ma_ff, sa_ff;
   logic signed [31:0]    ab_ff, mb_ff, sb_ff;
   logic                  agx_ff, agy_ff, mgx_ff, mgy_ff, sgx_ff, sgy_ff;
   logic [MW-1:0]         amx_ff, amy_ff;
   logic [MW-1:0]         amx_in, amy_in;
   logic [60:0]           px_ff [4];
   logic [60:0]           py_ff [4];
   logic [MW-1:0]         qx_ff, qy_ff;
   logic [121:0]          fx_sum, fy_sum;
   logic [36:0]           rx, ry;
   logic signed [36:0]    fx, fy;
   logic signed [31:0]    sat_x, sat_y;
   logic [31:0]           ang_out;
   logic signed [31:0]    out_x_ff, out_x_in;
   logic signed [31:0]    out_y_ff, out_y_in;
   logic signed [32:0]    out_m_ff, out_m_in;
   logic signed [31:0]    out_a_ff, out_a_in;

   assign adv      = !out_v_ff || rsp_ready;
   assign item_pop = adv && item_avail;

   assign amx_in = MW'(x_ff[N][CW-1] ? -x_ff[N] : x_ff[N]);
   assign amy_in = MW'(y_ff[N][CW-1] ? -y_ff[N] : y_ff[N]);

   always_comb begin
      fx_sum = 122'(px_ff[0]) + (122'(px_ff[1]) << 31) + (122'(px_ff[2]) << 30)
             + (122'(px_ff[3]) << 61);
      fy_sum = 122'(py_ff[0]) + (122'(py_ff[1]) << 31) + (122'(py_ff[2]) << 30)
             + (122'(py_ff[3]) << 61);
   end

   generate
      if (DATA_WIDTH > 32) begin : g_out_wide
         logic [DATA_WIDTH:0] zr;
         assign zr      = {1'b0, sz_ff} + ((DATA_WIDTH + 1)'(1) << (DATA_WIDTH - 33));
         assign ang_out = 32'(zr >> (DATA_WIDTH - 32));
      end else begin : g_out_narrow
         assign ang_out = 32'(sz_ff) << (32 - DATA_WIDTH);
      end
   endgenerate

   always_comb begin
      rx = 37'((60'(qx_ff) + (60'(1) << (cpc_pkg::GUARD_BITS - 1))) >> cpc_pkg::GUARD_BITS);
      ry = 37'((60'(qy_ff) + (60'(1) << (cpc_pkg::GUARD_BITS - 1))) >> cpc_pkg::GUARD_BITS);
      fx = sgx_ff ? -$signed(rx) : $signed(rx);
      fy = sgy_ff ? -$signed(ry) : $signed(ry);
      priority if (fx > 37'sd2147483647) begin
         sat_x = 32'sh7FFF_FFFF;
      end else if (fx < -37'sd2147483648) begin
         sat_x = 32'sh8000_0000;
      end else begin
         sat_x = 32'(fx);
      end
      priority if (fy > 37'sd2147483647) begin
         sat_y = 32'sh7FFF_FFFF;
      end else if (fy < -37'sd2147483648) begin
         sat_y = 32'sh8000_0000;
      end else begin
         sat_y = 32'(fy);
      end
      priority if (sc_ff.bad) begin
         out_x_in = '0;
         out_y_in = '0;
         out_m_in = '0;
         out_a_in = '0;
      end else if (sc_ff.polar) begin
         out_x_in = sat_x;
         out_y_in = sat_y;
         out_m_in = 33'(sa_ff);
         out_a_in = sb_ff;
      end else if (sc_ff.zero) begin
         out_x_in = sa_ff;
         out_y_in = sb_ff;
         out_m_in = '0;
         out_a_in = '0;
      end else begin
         out_x_in = sa_ff;
         out_y_in = sb_ff;
         out_m_in = 33'(fx);
         out_a_in = $signed(ang_out);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= N; k++) begin
            v_ff[k] <= 1'b0;
         end
         av_ff    <= 1'b0;
         mv_ff    <= 1'b0;
         sv_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= item_avail;
         for (int k = 0; k < N; k++) begin
            v_ff[k+1] <= v_ff[k];
         end
         av_ff    <= v_ff[N];
         mv_ff    <= av_ff;
         sv_ff    <= mv_ff;
         out_v_ff <= sv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_ff[0] <= ctrl;
         x_ff[0] <= x_start;
         y_ff[0] <= y_start;
         z_ff[0] <= z_start;
         a_ff[0] <= a_echo;
         b_ff[0] <= b_echo;
         for (int k = 0; k < N; k++) begin
            c_ff[k+1] <= c_ff[k];
            x_ff[k+1] <= x_in[k];
            y_ff[k+1] <= y_in[k];
            z_ff[k+1] <= z_in[k];
            a_ff[k+1] <= a_ff[k];
            b_ff[k+1] <= b_ff[k];
         end
         ac_ff  <= c_ff[N];
         az_ff  <= z_ff[N];
         aa_ff  <= a_ff[N];
         ab_ff  <= b_ff[N];
         agx_ff <= x_ff[N][CW-1];
         agy_ff <= y_ff[N][CW-1];
         amx_ff <= amx_in;
         amy_ff <= amy_in;
         mc_ff  <= ac_ff;
         mz_ff  <= az_ff;
         ma_ff  <= aa_ff;
         mb_ff  <= ab_ff;
         mgx_ff <= agx_ff;
         mgy_ff <= agy_ff;
         px_ff[0] <= 61'(amx_ff[29:0] * KINV_LO);
         px_ff[1] <= 61'(amx_ff[29:0] * KINV_HI);
         px_ff[2] <= 61'(amx_ff[MW-1:30] * KINV_LO);
         px_ff[3] <= 61'(amx_ff[MW-1:30] * KINV_HI);
         py_ff[0] <= 61'(amy_ff[29:0] * KINV_LO);
         py_ff[1] <= 61'(amy_ff[29:0] * KINV_HI);
         py_ff[2] <= 61'(amy_ff[MW-1:30] * KINV_LO);
         py_ff[3] <= 61'(amy_ff[MW-1:30] * KINV_HI);
         sc_ff  <= mc_ff;
         sz_ff  <= mz_ff;
         sa_ff  <= ma_ff;
         sb_ff  <= mb_ff;
         sgx_ff <= mgx_ff;
         sgy_ff <= mgy_ff;
         qx_ff  <= fx_sum[120:62];
         qy_ff  <= fy_sum[120:62];
         out_c_ff <= sc_ff;
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
         out_m_ff <= out_m_in;
         out_a_ff <= out_a_in;
      end
   end

   assign rsp_valid  = out_v_ff;
   assign x_coord    = out_x_ff;
   assign y_coord    = out_y_ff;
   assign magnitude  = out_m_ff;
   assign angle      = out_a_ff;
   assign polar_mode = out_c_ff.polar;
   assign bad_form   = out_c_ff.bad;

`ifndef ASSERT_OFF
   a_bad_zeroed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && bad_form |-> x_coord == 0 && y_coord == 0 && magnitude == 0
                                && angle == 0 && !polar_mode)
      else $error("invalid form result carries data");
   a_mode_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(polar_mode && bad_form)) else $error("polar and invalid both set");
   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !polar_mode && x_coord == 0 && y_coord == 0 |-> magnitude == 0 && angle == 0)
      else $error("zero vector gave nonzero length or angle");
`endif

endmodule
